// ===== design/slab_free_list_allocator_defines.svh =====
// assertion macros shared by the allocator checker
`ifndef SLAB_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define SLAB_FREE_LIST_ALLOCATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SFLA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SFLA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sfla_pkg.sv =====
// shared types and constants of the slab free list allocator
`default_nettype none

package sfla_pkg;

  localparam int ADDR_W       = 32;
  localparam int STATUS_W     = 3;
  localparam int FREE_COUNT_W = 11;
  localparam int OUT_DATA_W   = 48;

  localparam logic [ADDR_W-1:0] POOL_BASE_RESET = 32'd65536;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_NULL        = 3'd1,
    ST_TOO_MANY    = 3'd2,
    ST_NOT_IN_POOL = 3'd3,
    ST_DOUBLE      = 3'd4,
    ST_OOM         = 3'd5
  } status_t;

  // status of the reciprocal-multiply divide unit
  typedef struct packed {
    logic done;
    logic exact;
  } div_stat_t;

endpackage

`default_nettype wire

// ===== design/sfla_ram.sv =====
// generic single write port, single read port ram with registered read
`default_nettype none

module sfla_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/sfla_div.sv =====
// divide by a fixed divisor through a reciprocal multiply; done rises after the multiply and check states
`default_nettype none

module sfla_div #(
  parameter int QUOT_W  = 10,
  parameter int NUM_W   = 19,
  parameter int DIVISOR = 512
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [31:0]         dividend,
  output logic      [QUOT_W-1:0]   quot,
  output sfla_pkg::div_stat_t      stat
);

  // floor(x * RECIP / 2^SHIFT) equals floor(x / DIVISOR) for every x below 2^NUM_W
  localparam int SH_L   = (DIVISOR > 1) ? $clog2(DIVISOR) : 0;
  localparam int SHIFT  = NUM_W + SH_L;
  localparam int REC_W  = NUM_W + 2;
  localparam int PROD_W = NUM_W + REC_W;
  localparam longint unsigned REC_VAL =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [REC_W-1:0] RECIP = REC_W'(REC_VAL);

  typedef enum logic [1:0] {
    D_IDLE, D_MUL, D_CHECK
  } div_state_t;

  div_state_t        phase;
  logic [NUM_W-1:0]  num;
  logic [PROD_W-1:0] prod;
  logic [NUM_W-1:0]  back;
  logic              done;
  logic              exact;

  assign prod = PROD_W'(num) * PROD_W'(RECIP);
  assign back = NUM_W'(quot) * NUM_W'(DIVISOR);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        D_IDLE: begin
          if (start) begin
            num   <= dividend[NUM_W-1:0];
            phase <= D_MUL;
          end
        end
        D_MUL: begin
          quot  <= QUOT_W'(prod >> SHIFT);
          phase <= D_CHECK;
        end
        D_CHECK: begin
          // a whole number of slabs leaves no remainder
          exact <= (back == num);
          done  <= 1'b1;
          phase <= D_IDLE;
        end
        default: begin
          phase <= D_IDLE;
        end
      endcase
    end
  end

  assign stat.done  = done;
  assign stat.exact = exact;

endmodule

`default_nettype wire

// ===== design/slab_free_list_allocator.sv =====
// slab allocator: alloc passes POP_RD, POP_MUL and POP_ADD to RESP (out of memory goes straight
// to RESP); an empty stack first takes a gulp in REFILL at one push per cycle.
// free: CHECK, RANGE, a reciprocal divide in DIV, then SCAN reads one stack entry
// per cycle in the double-free scan; early rejects answer from CHECK, RANGE or DIV.
// one request at a time; the next is taken once the result sits in the output register.
// reset: counts and gulps cleared, pool_base 65536, stack ram contents not cleared.
`default_nettype none

module slab_free_list_allocator #(
  parameter int SLABS_PER_GULP = 128,
  parameter int SLAB_BYTES     = 512,
  parameter int MAX_GULPS      = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_wr_en,
  input  wire logic [sfla_pkg::ADDR_W-1:0]         cfg_wr_data,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // [31:0] slab_address
  input  wire logic [sfla_pkg::ADDR_W-1:0]         s_axis_tdata,
  // [0] operation
  input  wire logic                                s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // [31:0] granted_address, [42:32] free_count, [47:43] zero
  output logic [sfla_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
  // [2:0] status
  output logic [sfla_pkg::STATUS_W-1:0]            m_axis_tuser
);

  localparam int DEPTH  = MAX_GULPS * SLABS_PER_GULP;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int GUL_W  = $clog2(MAX_GULPS + 1);
  localparam int FILL_W = (SLABS_PER_GULP > 1) ? $clog2(SLABS_PER_GULP) : 1;
  localparam logic [32:0] GULP_BYTES = 33'(SLABS_PER_GULP * SLAB_BYTES);
  localparam longint POOL_BYTES = longint'(DEPTH) * longint'(SLAB_BYTES);
  localparam int OFF_W  = (POOL_BYTES > 1) ? $clog2(POOL_BYTES) : 1;

  typedef enum logic [3:0] {
    IDLE, CHECK, RANGE, DIV, SCAN, REFILL, POP_RD, POP_MUL, POP_ADD, RESP
  } state_t;

  state_t                        state;
  logic [sfla_pkg::ADDR_W-1:0]   pool_base;
  logic [sfla_pkg::ADDR_W-1:0]   addr_r;
  logic [31:0]                   off;
  logic [32:0]                   span;
  logic [CNT_W-1:0]              count;
  logic [CNT_W-1:0]              cap;
  logic [GUL_W-1:0]              gulps;
  logic [FILL_W-1:0]             fill_cnt;
  logic [CNT_W-1:0]              scan_ptr;
  logic                          pend;
  logic [IDX_W-1:0]              idx;
  logic [31:0]                   prod;
  logic [sfla_pkg::ADDR_W-1:0]   res_addr;
  sfla_pkg::status_t             res_status;

  logic                          ram_we;
  logic [IDX_W-1:0]              ram_waddr;
  logic [IDX_W-1:0]              ram_wdata;
  logic [IDX_W-1:0]              ram_raddr;
  logic [IDX_W-1:0]              ram_rdata;
  logic [CNT_W-1:0]              cnt_dec;

  logic                          div_start;
  logic [IDX_W-1:0]              div_quot;
  sfla_pkg::div_stat_t           div_stat;

  logic                          ge_span;
  logic                          hit;
  logic                          out_free;

  assign s_axis_tready = (state == IDLE);
  assign cnt_dec       = count - 1'b1;
  assign ge_span       = {1'b0, off} >= span;
  assign hit           = pend && (ram_rdata == idx);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign div_start     = (state == RANGE) && !ge_span;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[IDX_W-1:0];
    ram_wdata = idx;
    ram_raddr = scan_ptr[IDX_W-1:0];
    case (state)
      REFILL: begin
        ram_we    = 1'b1;
        ram_wdata = IDX_W'(cap + CNT_W'(fill_cnt));
      end
      SCAN: begin
        ram_we = !hit && (scan_ptr == count);
      end
      POP_RD: begin
        ram_raddr = cnt_dec[IDX_W-1:0];
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  sfla_ram #(
    .WIDTH(IDX_W),
    .DEPTH(DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  sfla_div #(
    .QUOT_W (IDX_W),
    .NUM_W  (OFF_W),
    .DIVISOR(SLAB_BYTES)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(off),
    .quot    (div_quot),
    .stat    (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      pool_base     <= sfla_pkg::POOL_BASE_RESET;
      count         <= '0;
      cap           <= '0;
      gulps         <= '0;
      span          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        pool_base <= cfg_wr_data;
      end
      // the response state sets or holds valid itself
      if (m_axis_tready && (state != RESP)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (s_axis_tvalid) begin
            addr_r <= s_axis_tdata;
            if (s_axis_tuser == sfla_pkg::OP_FREE) begin
              state <= CHECK;
            end else if (count != '0) begin
              state <= POP_RD;
            end else if (gulps >= GUL_W'(MAX_GULPS)) begin
              res_addr   <= '0;
              res_status <= sfla_pkg::ST_OOM;
              state      <= RESP;
            end else begin
              fill_cnt <= '0;
              state    <= REFILL;
            end
          end
        end
        CHECK: begin
          res_addr <= '0;
          if (addr_r == '0) begin
            res_status <= sfla_pkg::ST_NULL;
            state      <= RESP;
          end else if (count >= cap) begin
            res_status <= sfla_pkg::ST_TOO_MANY;
            state      <= RESP;
          end else if (addr_r < pool_base) begin
            res_status <= sfla_pkg::ST_NOT_IN_POOL;
            state      <= RESP;
          end else begin
            off   <= addr_r - pool_base;
            state <= RANGE;
          end
        end
        RANGE: begin
          if (ge_span) begin
            res_status <= sfla_pkg::ST_NOT_IN_POOL;
            state      <= RESP;
          end else begin
            state <= DIV;
          end
        end
        DIV: begin
          if (div_stat.done) begin
            if (!div_stat.exact) begin
              res_status <= sfla_pkg::ST_NOT_IN_POOL;
              state      <= RESP;
            end else begin
              idx      <= div_quot;
              scan_ptr <= '0;
              pend     <= 1'b0;
              state    <= SCAN;
            end
          end
        end
        SCAN: begin
          // read data comes from the registered ram read, so it lags the read address
          if (hit) begin
            res_status <= sfla_pkg::ST_DOUBLE;
            state      <= RESP;
          end else if (scan_ptr == count) begin
            count      <= count + 1'b1;
            res_status <= sfla_pkg::ST_OK;
            state      <= RESP;
          end else begin
            scan_ptr <= scan_ptr + 1'b1;
            pend     <= 1'b1;
          end
        end
        REFILL: begin
          count    <= count + 1'b1;
          fill_cnt <= fill_cnt + 1'b1;
          if (fill_cnt == FILL_W'(SLABS_PER_GULP - 1)) begin
            gulps <= gulps + 1'b1;
            cap   <= cap + CNT_W'(SLABS_PER_GULP);
            span  <= span + GULP_BYTES;
            state <= POP_RD;
          end
        end
        POP_RD: begin
          count <= cnt_dec;
          state <= POP_MUL;
        end
        POP_MUL: begin
          prod  <= 32'(ram_rdata) * 32'(SLAB_BYTES);
          state <= POP_ADD;
        end
        POP_ADD: begin
          res_addr   <= pool_base + prod;
          res_status <= sfla_pkg::ST_OK;
          state      <= RESP;
        end
        RESP: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {5'b0, 11'(count), res_addr};
            m_axis_tuser  <= res_status;
            state         <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/sfla_checker.sv =====
// port-level assertions for the slab allocator and their bind
`default_nettype none
`include "slab_free_list_allocator_defines.svh"

module sfla_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                cfg_wr_en,
  input wire logic [sfla_pkg::ADDR_W-1:0]         cfg_wr_data,
  input wire logic                                s_axis_tvalid,
  input wire logic                                s_axis_tready,
  input wire logic [sfla_pkg::ADDR_W-1:0]         s_axis_tdata,
  input wire logic                                s_axis_tuser,
  input wire logic                                m_axis_tvalid,
  input wire logic                                m_axis_tready,
  input wire logic [sfla_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input wire logic [sfla_pkg::STATUS_W-1:0]       m_axis_tuser
);

  `SFLA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
    "stalled result changed")

  `SFLA_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready,
    !s_axis_tready, "request taken while another is in progress")

  `SFLA_ASSERT_SAME(a_fail_no_addr,
    m_axis_tvalid && (m_axis_tuser != sfla_pkg::ST_OK),
    m_axis_tdata[31:0] == 32'd0, "failed request granted an address")

  `SFLA_ASSERT_SAME(a_oom_empty,
    m_axis_tvalid && (m_axis_tuser == sfla_pkg::ST_OOM),
    m_axis_tdata[42:32] == 11'd0, "out of memory with slabs still free")

endmodule

bind slab_free_list_allocator sfla_checker u_sfla_checker (.*);

`default_nettype wire

// ===== bench/testbench.sv =====
// self-checking bench for the slab free list allocator: directed and random alloc/free traffic
`default_nettype none

module testbench;

  localparam int SLABS_PER_GULP = 128;
  localparam int SLAB_BYTES     = 512;
  localparam int MAX_GULPS      = 8;
  localparam int STACK_DEPTH    = MAX_GULPS * SLABS_PER_GULP;
  localparam int LIMIT          = 8000000;

  typedef struct {
    logic [sfla_pkg::ADDR_W-1:0]       granted;
    sfla_pkg::status_t                 status;
    logic [sfla_pkg::FREE_COUNT_W-1:0] free_count;
  } reply_t;

  class alloc_scoreboard;
    logic [sfla_pkg::ADDR_W-1:0] base;
    logic [9:0]                  free_slabs [STACK_DEPTH];
    int unsigned                 depth;
    int unsigned                 gulps;
    int                          errors;
    reply_t                      expected_replies [$];

    function new();
      base   = sfla_pkg::POOL_BASE_RESET;
      depth  = 0;
      gulps  = 0;
      errors = 0;
    endfunction

    // predicts the reply of one accepted request and queues it
    function void note_request(input logic op, input logic [sfla_pkg::ADDR_W-1:0] addr,
                               output sfla_pkg::status_t st, output int slab_idx);
      reply_t           r;
      longint unsigned  span;
      longint unsigned  off;
      int               i;
      bit               hit;
      r.granted = '0;
      slab_idx  = -1;
      if (op == sfla_pkg::OP_ALLOC) begin
        if (depth == 0 && gulps >= MAX_GULPS) begin
          r.status = sfla_pkg::ST_OOM;
        end else begin
          // empty stack: take a gulp, lowest slab pushed first
          if (depth == 0) begin
            for (i = 0; i < SLABS_PER_GULP; i++) begin
              free_slabs[depth] = 10'(gulps * SLABS_PER_GULP + i);
              depth++;
            end
            gulps++;
          end
          depth--;
          slab_idx  = int'(free_slabs[depth]);
          r.granted = base + 32'(slab_idx * SLAB_BYTES);
          r.status  = sfla_pkg::ST_OK;
        end
      end else if (addr == '0) begin
        r.status = sfla_pkg::ST_NULL;
      end else if (depth >= gulps * SLABS_PER_GULP) begin
        r.status = sfla_pkg::ST_TOO_MANY;
      end else begin
        span = longint'(gulps) * SLABS_PER_GULP * SLAB_BYTES;
        off  = {32'd0, addr} - {32'd0, base};
        if (addr < base || off >= span || (off % SLAB_BYTES) != 0) begin
          r.status = sfla_pkg::ST_NOT_IN_POOL;
        end else begin
          slab_idx = int'(off / SLAB_BYTES);
          hit = 1'b0;
          for (i = 0; i < int'(depth); i++) begin
            if (int'(free_slabs[i]) == slab_idx) hit = 1'b1;
          end
          if (hit) begin
            r.status = sfla_pkg::ST_DOUBLE;
            slab_idx = -1;
          end else begin
            free_slabs[depth] = 10'(slab_idx);
            depth++;
            r.status = sfla_pkg::ST_OK;
          end
        end
      end
      r.free_count = 11'(depth);
      st = r.status;
      expected_replies.insert(expected_replies.size(), r);
    endfunction

    function void check_reply(input logic [sfla_pkg::OUT_DATA_W-1:0] data,
                              input logic [sfla_pkg::STATUS_W-1:0] user);
      reply_t want;
      if (expected_replies.size() == 0) begin
        $display("%0t: result with none expected: expected none actual %h/%h",
                 $time, data, user);
        errors++;
        return;
      end
      want = expected_replies.pop_front();
      if (data[31:0] !== want.granted) begin
        $display("%0t: granted_address expected %h actual %h", $time, want.granted,
                 data[31:0]);
        errors++;
      end
      if (user !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, user);
        errors++;
      end
      if (data[42:32] !== want.free_count) begin
        $display("%0t: free_count expected %0d actual %0d", $time, want.free_count,
                 data[42:32]);
        errors++;
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_wr_en = 1'b0;
  logic [sfla_pkg::ADDR_W-1:0]     cfg_wr_data = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  // [31:0] slab_address
  logic [sfla_pkg::ADDR_W-1:0]     s_axis_tdata = '0;
  // [0] operation
  logic                            s_axis_tuser = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  // [31:0] granted_address, [42:32] free_count, [47:43] zero
  logic [sfla_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  // [2:0] status
  logic [sfla_pkg::STATUS_W-1:0]   m_axis_tuser;

  alloc_scoreboard ledger;
  bit              steady = 1'b0;
  int              cycles = 0;
  int              held [$];
  int              released [$];

  slab_free_list_allocator #(
    .SLABS_PER_GULP(SLABS_PER_GULP),
    .SLAB_BYTES    (SLAB_BYTES),
    .MAX_GULPS     (MAX_GULPS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 10);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) ledger.check_reply(m_axis_tdata, m_axis_tuser);
  end

  function automatic int held_pos(input int idx);
    foreach (held[i]) begin
      if (held[i] == idx) return i;
    end
    return -1;
  endfunction

  function automatic logic [sfla_pkg::ADDR_W-1:0] slab_addr(input int idx);
    return ledger.base + 32'(idx * SLAB_BYTES);
  endfunction

  function automatic logic [sfla_pkg::ADDR_W-1:0] noise_addr();
    logic [sfla_pkg::ADDR_W-1:0] a;
    case ($urandom_range(4))
      0: a = '0;
      1: a = $urandom;
      2: a = slab_addr($urandom_range(STACK_DEPTH - 1)) + $urandom_range(1, SLAB_BYTES - 1);
      3: a = slab_addr(int'(ledger.gulps) * SLABS_PER_GULP + int'($urandom_range(3)));
      default: a = ledger.base - $urandom_range(1, 8192);
    endcase
    return a;
  endfunction

  // one request transfer, then bookkeeping of which slabs the bench holds
  task automatic request(input logic op, input logic [sfla_pkg::ADDR_W-1:0] addr,
                         output sfla_pkg::status_t st);
    int g;
    int idx;
    int pos;
    if (!steady && $urandom_range(99) < 10) begin
      g = $urandom_range(1, 4);
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= addr;
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    ledger.note_request(op, addr, st, idx);
    if (st == sfla_pkg::ST_OK) begin
      if (op == sfla_pkg::OP_ALLOC) begin
        held.insert(held.size(), idx);
      end else begin
        pos = held_pos(idx);
        if (pos >= 0) held.delete(pos);
        released.insert(released.size(), idx);
        if (released.size() > 32) void'(released.pop_front());
      end
    end
  endtask

  // register writes only with nothing in flight
  task automatic write_pool_base(input logic [sfla_pkg::ADDR_W-1:0] value);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (ledger.expected_replies.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    ledger.base = value;
  endtask

  task automatic random_traffic(input int count, input int alloc_pct);
    int                r;
    sfla_pkg::status_t st;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < alloc_pct) begin
        request(sfla_pkg::OP_ALLOC, $urandom, st);
      end else if (r < 88 && held.size() > 0) begin
        request(sfla_pkg::OP_FREE, slab_addr(held[$urandom_range(held.size() - 1)]), st);
      end else if (r < 94 && released.size() > 0) begin
        request(sfla_pkg::OP_FREE,
                slab_addr(released[$urandom_range(released.size() - 1)]), st);
      end else begin
        request(sfla_pkg::OP_FREE, noise_addr(), st);
      end
    end
  endtask

  initial begin
    sfla_pkg::status_t           st;
    logic [sfla_pkg::ADDR_W-1:0] p;
    ledger = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    p = sfla_pkg::POOL_BASE_RESET;
    request(sfla_pkg::OP_FREE, 32'd0, st);
    request(sfla_pkg::OP_FREE, p, st);
    request(sfla_pkg::OP_ALLOC, 32'hFFFF_FFFF, st);
    request(sfla_pkg::OP_ALLOC, 32'd0, st);
    request(sfla_pkg::OP_FREE, p + 127 * SLAB_BYTES, st);
    request(sfla_pkg::OP_FREE, p + 127 * SLAB_BYTES, st);
    // slab 0 sits in stack entry 0
    request(sfla_pkg::OP_FREE, p, st);
    request(sfla_pkg::OP_FREE, p - SLAB_BYTES, st);
    request(sfla_pkg::OP_FREE, p + SLABS_PER_GULP * SLAB_BYTES, st);
    request(sfla_pkg::OP_FREE, p + 1, st);
    request(sfla_pkg::OP_FREE, 32'hFFFF_FFFF, st);
    request(sfla_pkg::OP_FREE, p + 126 * SLAB_BYTES, st);
    request(sfla_pkg::OP_FREE, p + 5 * SLAB_BYTES, st);

    // long run of allocs across a gulp refill, no idling here
    steady = 1'b1;
    repeat (180) request(sfla_pkg::OP_ALLOC, $urandom, st);
    steady = 1'b0;

    write_pool_base(32'd1);
    random_traffic(80, 25);

    write_pool_base(32'hFFF0_0000);
    random_traffic(60, 40);
    // put slab 0 on top so the zero base grants address 0
    while (held_pos(0) < 0) request(sfla_pkg::OP_ALLOC, $urandom, st);
    request(sfla_pkg::OP_FREE, slab_addr(0), st);

    write_pool_base(32'd0);
    request(sfla_pkg::OP_ALLOC, $urandom, st);
    request(sfla_pkg::OP_FREE, 32'd0, st);
    random_traffic(30, 40);

    // granted addresses wrap past the top of the address space
    write_pool_base(32'hFFFF_FE00);
    random_traffic(30, 45);

    write_pool_base(sfla_pkg::POOL_BASE_RESET);
    random_traffic(40, 50);

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (ledger.expected_replies.size() != 0) @(posedge clk);
    repeat (1100) @(posedge clk);
    if (ledger.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
